### hdl/pfrt_pkg.sv
// Shared types, constants and helpers for the pinned FIFO replacement table.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package pfrt_pkg;

  // Default sizing of the table
  localparam int CAPACITY_DEF    = 10;
  localparam int HANDLE_BITS_DEF = 32;

  // Fixed widths of the channel payload
  localparam int KIND_W   = 3;
  localparam int IDX_W    = 4;
  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD    = 3'd0,
    OP_READ   = 3'd1,
    OP_PIN    = 3'd2,
    OP_UNPIN  = 3'd3,
    OP_REMOVE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_PIN_LIMIT = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                cmp_en;   // register the per-cell hit flag
    logic                upd_en;   // apply the operation
    op_e_t               kind;
    logic [IDX_W-1:0]    idx;
    logic [HANDLE_W-1:0] key;
    logic                full;
    logic                any_hit;
    logic                pin_ok;
  } ctl_t;

  // Status reported by each cell to the controller
  typedef struct packed {
    logic                valid;
    logic                pinned;
    logic                sel_valid;   // addressed by idx and occupied
    logic                sel_pinned;  // addressed, occupied and pinned
    logic                drop_pin;    // this cell is dropped and was pinned
    logic [HANDLE_W-1:0] rd_handle;   // stored handle when addressed, else zero
  } cell_st_t;

  // Bits actually kept per entry: the handle is masked to HANDLE_BITS
  function automatic int store_bits(input int hb);
    return (hb < HANDLE_W) ? hb : HANDLE_W;
  endfunction

endpackage

`default_nettype wire

### hdl/pfrt_in_if.sv
// Operation channel of the pinned FIFO replacement table.
// Depends on pfrt_pkg for the payload widths.
`default_nettype none

interface pfrt_in_if;
  logic                           valid;
  logic                           ready;
  logic [pfrt_pkg::KIND_W-1:0]    kind;
  logic [pfrt_pkg::IDX_W-1:0]     entry_index;
  logic [pfrt_pkg::HANDLE_W-1:0]  handle;

  modport source (output valid, kind, entry_index, handle, input ready);
  modport sink   (input valid, kind, entry_index, handle, output ready);
endinterface

`default_nettype wire

### hdl/pfrt_out_if.sv
// Result channel of the pinned FIFO replacement table.
// Depends on pfrt_pkg for the payload widths.
`default_nettype none

interface pfrt_out_if;
  logic                           valid;
  logic                           ready;
  logic [pfrt_pkg::HANDLE_W-1:0]  read_handle;
  logic                           read_valid;
  logic [pfrt_pkg::COUNT_W-1:0]   entry_count;
  logic [pfrt_pkg::STATUS_W-1:0]  status;

  modport source (output valid, read_handle, read_valid, entry_count, status, input ready);
  modport sink   (input valid, read_handle, read_valid, entry_count, status, output ready);
endinterface

`default_nettype wire

### hdl/pfrt_cell.sv
// One position of the compacting list: handle, pin flag, occupancy and match flag.
// Depends on pfrt_pkg; instanced in a row by pinned_fifo_replacement_table.
`default_nettype none

module pfrt_cell #(
  parameter  int POS         = 0,
  parameter  int HANDLE_BITS = pfrt_pkg::HANDLE_BITS_DEF,
  localparam int SW          = pfrt_pkg::store_bits(HANDLE_BITS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfrt_pkg::ctl_t    ctl,
  input  wire logic              left_valid,   // occupancy of the cell to the left
  input  wire logic              seen_in,      // a hit exists further left
  output logic                   seen_out,
  input  wire logic [SW-1:0]     right_handle, // entry of the cell to the right
  input  wire logic              right_valid,
  input  wire logic              right_pinned,
  output logic [SW-1:0]          handle_out,
  output pfrt_pkg::cell_st_t     st
);

  logic [SW-1:0] handle_r;
  logic          valid_r;
  logic          pinned_r;
  logic          hit_r;

  logic sel;
  logic is_add;
  logic shift_mode;
  logic do_shift;
  logic first;
  logic append;
  logic do_pin;
  logic do_unpin;

  // Decode the broadcast operation for this position
  always_comb begin
    is_add     = (ctl.kind == pfrt_pkg::OP_ADD);
    sel        = (int'(ctl.idx) == POS);
    shift_mode = (is_add && ctl.full) || ((ctl.kind == pfrt_pkg::OP_REMOVE) && ctl.any_hit);
    do_shift   = shift_mode && (seen_in || hit_r || (is_add && !ctl.any_hit));
    first      = shift_mode && ((hit_r && !seen_in) || (is_add && !ctl.any_hit && (POS == 0)));
    append     = is_add && !ctl.full && !valid_r && left_valid;
    do_pin     = (ctl.kind == pfrt_pkg::OP_PIN) && ctl.pin_ok && sel && valid_r;
    do_unpin   = (ctl.kind == pfrt_pkg::OP_UNPIN) && sel && valid_r;
  end

  // Control state: occupancy, pin flag, hit flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      pinned_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        hit_r <= valid_r && ((ctl.kind == pfrt_pkg::OP_REMOVE) ?
                             (handle_r == ctl.key[SW-1:0]) : !pinned_r);
      end
      if (ctl.upd_en) begin
        priority if (ctl.kind == pfrt_pkg::OP_CLEAR) begin
          valid_r  <= 1'b0;
          pinned_r <= 1'b0;
        end else if (do_shift) begin
          valid_r  <= right_valid;
          pinned_r <= right_pinned;
        end else if (append) begin
          valid_r  <= 1'b1;
          pinned_r <= 1'b0;
        end else if (do_pin) begin
          pinned_r <= 1'b1;
        end else if (do_unpin) begin
          pinned_r <= 1'b0;
        end
      end
    end
  end

  // Handle payload: advance from the right neighbour or load a new one
  always_ff @(posedge clk) begin
    if (ctl.upd_en && (ctl.kind != pfrt_pkg::OP_CLEAR)) begin
      if (do_shift) begin
        handle_r <= right_handle;
      end else if (append) begin
        handle_r <= ctl.key[SW-1:0];
      end
    end
  end

  // Hand status and data to the neighbours and the controller
  always_comb begin
    seen_out      = seen_in | hit_r;
    handle_out    = handle_r;
    st.valid      = valid_r;
    st.pinned     = pinned_r;
    st.sel_valid  = sel && valid_r;
    st.sel_pinned = sel && valid_r && pinned_r;
    st.drop_pin   = first && pinned_r;
    st.rd_handle  = (sel && valid_r) ? pfrt_pkg::HANDLE_W'(handle_r) : '0;
  end

endmodule

`default_nettype wire

### hdl/pinned_fifo_replacement_table.sv
// Pinned FIFO replacement table: an ordered, compacting list of up to CAPACITY
// handles, each with a pin flag, held in a row of pfrt_cell instances.
//
// in_ch carries one operation per beat (add, read, pin, unpin, remove by
// handle, clear); out_ch returns exactly one result beat per operation with
// the read handle, read flag, entry count and status. Both use valid/ready.
//
// An accepted operation passes through the compare, update and done states:
// compare registers the per-cell match flags (handle compare or "unpinned"),
// update ripples the first-hit mark along the row, lets every cell hold,
// advance from its right neighbour, load or change its pin flag and registers
// the result, and done moves the result into the output register once that is
// free. A new operation is accepted only after the block is back in idle, so
// it never takes a new operation before the last one has left the done state.
// The result register separates the channels: the next operation is taken
// while a result still waits; if the receiver stalls, the finished result
// of that next operation is held until the output register frees up.
// Reset (synchronous, rst_n low) empties the list and clears all pin flags;
// no clearing pass is needed.
`default_nettype none

module pinned_fifo_replacement_table #(
  parameter int CAPACITY    = pfrt_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = pfrt_pkg::HANDLE_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  pfrt_in_if.sink    in_ch,
  pfrt_out_if.source out_ch
);

  localparam int SW = pfrt_pkg::store_bits(HANDLE_BITS);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD, S_DONE} state_t;

  state_t                         state_r;
  pfrt_pkg::op_e_t                kind_r;
  logic [pfrt_pkg::IDX_W-1:0]     idx_r;
  logic [pfrt_pkg::HANDLE_W-1:0]  key_r;
  logic [CW-1:0]                  count_r;
  logic [CW-1:0]                  count_nxt;
  logic [CW-1:0]                  pin_cnt_r;
  logic [CW-1:0]                  pin_cnt_nxt;

  logic [pfrt_pkg::HANDLE_W-1:0]  res_handle_r;
  logic                           res_rvalid_r;
  logic [pfrt_pkg::COUNT_W-1:0]   res_count_r;
  pfrt_pkg::status_e_t            res_status_r;
  logic [pfrt_pkg::HANDLE_W-1:0]  res_handle_nxt;
  logic                           res_rvalid_nxt;
  pfrt_pkg::status_e_t            res_status_nxt;

  logic                           out_valid_r;
  logic [pfrt_pkg::HANDLE_W-1:0]  out_handle_r;
  logic                           out_rvalid_r;
  logic [pfrt_pkg::COUNT_W-1:0]   out_count_r;
  pfrt_pkg::status_e_t            out_status_r;

  pfrt_pkg::ctl_t                 ctl;
  pfrt_pkg::cell_st_t             cst [CAPACITY];
  logic                           seen      [CAPACITY+1];
  logic                           lvalid    [CAPACITY+1];
  logic [SW-1:0]                  nb_handle [CAPACITY+1];
  logic                           nb_valid  [CAPACITY+1];
  logic                           nb_pinned [CAPACITY+1];

  logic [CAPACITY-1:0]            valid_vec;
  logic [CAPACITY-1:0]            pin_vec;
  logic                           in_range;
  logic                           sel_pinned;
  logic                           drop_pin;
  logic [pfrt_pkg::HANDLE_W-1:0]  rd_handle;
  logic                           full;
  logic                           pin_ok;
  logic                           in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign full   = (count_r == CW'(CAPACITY));
  assign pin_ok = (pin_cnt_r < CW'(CAPACITY - 1));

  // Broadcast the latched operation to the row
  always_comb begin
    ctl.cmp_en  = (state_r == S_CMP);
    ctl.upd_en  = (state_r == S_UPD);
    ctl.kind    = kind_r;
    ctl.idx     = idx_r;
    ctl.key     = key_r;
    ctl.full    = full;
    ctl.any_hit = seen[CAPACITY];
    ctl.pin_ok  = pin_ok;
  end

  // Ends of the row: nothing to the left, the new entry beyond the tail on add
  assign seen[0]             = 1'b0;
  assign lvalid[0]           = 1'b1;
  assign nb_handle[CAPACITY] = key_r[SW-1:0];
  assign nb_valid[CAPACITY]  = (kind_r == pfrt_pkg::OP_ADD);
  assign nb_pinned[CAPACITY] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pfrt_cell #(
      .POS         (i),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .left_valid   (lvalid[i]),
      .seen_in      (seen[i]),
      .seen_out     (seen[i+1]),
      .right_handle (nb_handle[i+1]),
      .right_valid  (nb_valid[i+1]),
      .right_pinned (nb_pinned[i+1]),
      .handle_out   (nb_handle[i]),
      .st           (cst[i])
    );
    assign nb_valid[i]  = cst[i].valid;
    assign nb_pinned[i] = cst[i].pinned;
    assign lvalid[i+1]  = cst[i].valid;
    assign valid_vec[i] = cst[i].valid;
    assign pin_vec[i]   = cst[i].pinned;
  end

  // Gather addressed-entry data and the dropped entry's pin flag
  always_comb begin
    in_range   = 1'b0;
    sel_pinned = 1'b0;
    drop_pin   = 1'b0;
    rd_handle  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      in_range   = in_range   | cst[i].sel_valid;
      sel_pinned = sel_pinned | cst[i].sel_pinned;
      drop_pin   = drop_pin   | cst[i].drop_pin;
      rd_handle  = rd_handle  | cst[i].rd_handle;
    end
  end

  // Work out counts and the result of the operation
  always_comb begin
    count_nxt      = count_r;
    pin_cnt_nxt    = pin_cnt_r;
    res_handle_nxt = '0;
    res_rvalid_nxt = 1'b0;
    res_status_nxt = pfrt_pkg::ST_OK;
    unique case (kind_r)
      pfrt_pkg::OP_ADD: begin
        if (full) begin
          pin_cnt_nxt = pin_cnt_r - CW'(drop_pin);
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      pfrt_pkg::OP_READ: begin
        if (in_range) begin
          res_handle_nxt = rd_handle;
          res_rvalid_nxt = 1'b1;
        end else begin
          res_status_nxt = pfrt_pkg::ST_RANGE;
        end
      end
      pfrt_pkg::OP_PIN: begin
        if (!pin_ok) begin
          res_status_nxt = pfrt_pkg::ST_PIN_LIMIT;
        end else if (in_range) begin
          pin_cnt_nxt = pin_cnt_r + CW'(!sel_pinned);
        end else begin
          res_status_nxt = pfrt_pkg::ST_RANGE;
        end
      end
      pfrt_pkg::OP_UNPIN: begin
        if (in_range) begin
          pin_cnt_nxt = pin_cnt_r - CW'(sel_pinned);
        end else begin
          res_status_nxt = pfrt_pkg::ST_RANGE;
        end
      end
      pfrt_pkg::OP_REMOVE: begin
        if (ctl.any_hit) begin
          count_nxt   = count_r - CW'(1);
          pin_cnt_nxt = pin_cnt_r - CW'(drop_pin);
        end else begin
          res_status_nxt = pfrt_pkg::ST_NOT_FOUND;
        end
      end
      pfrt_pkg::OP_CLEAR: begin
        count_nxt   = '0;
        pin_cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, counts and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pin_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the taken beat unless a new result is loaded this cycle
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            kind_r  <= pfrt_pkg::op_e_t'(in_ch.kind);
            idx_r   <= in_ch.entry_index;
            key_r   <= in_ch.handle;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          count_r      <= count_nxt;
          pin_cnt_r    <= pin_cnt_nxt;
          res_handle_r <= res_handle_nxt;
          res_rvalid_r <= res_rvalid_nxt;
          res_count_r  <= pfrt_pkg::COUNT_W'(count_nxt);
          res_status_r <= res_status_nxt;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_handle_r <= res_handle_r;
            out_rvalid_r <= res_rvalid_r;
            out_count_r  <= res_count_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_handle = out_handle_r;
  assign out_ch.read_valid  = out_rvalid_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.status      = out_status_r;

  // Occupied cells match the entry count
  a_count_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("occupied cells disagree with entry count");

  // Pin counter tracks the pin flags of the row
  a_pin_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pin_vec) == int'(pin_cnt_r))
    else $error("pin counter disagrees with pinned cells");

  // Only occupied cells carry a pin flag
  a_pin_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (pin_vec & ~valid_vec) == '0)
    else $error("pin flag on an empty cell");

  // An accepted beat starts the compare step next
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_CMP))
    else $error("accepted beat did not start the compare step");

endmodule

`default_nettype wire
